[rtl/c_subset_token_lexer_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the lexer core
// ---------------------------------------------------------------------------
`ifndef C_SUBSET_TOKEN_LEXER_CORE_ASSERT_SVH
`define C_SUBSET_TOKEN_LEXER_CORE_ASSERT_SVH
// check a property on the rising clock, off during reset
`define CSTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// check a property on the rising clock, active during reset too
`define CSTL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

[rtl/cstl_pkg.sv]
// ---------------------------------------------------------------------------
// cstl_pkg
// Types, codes and decode helpers shared by the lexer core.
// ---------------------------------------------------------------------------
package cstl_pkg;

    localparam int unsigned MaxSource   = 4194304;
    localparam int unsigned MaxStrings  = 8192;
    localparam int unsigned StringStore = 1048576;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_ZERO, M_DEC, M_HEX, M_PEND, M_SLASH, M_LINECMT,
        M_BLOCK, M_BSTAR, M_CHOPEN, M_CHESC, M_CHCLOSE, M_STR, M_STRESC,
        M_DONE, M_ERROR
    } t_mode;

    typedef enum logic [2:0] {
        K_EOF = 3'd0, K_IDENT = 3'd1, K_NUM = 3'd2, K_STRING = 3'd3,
        K_PUNCT = 3'd4, K_SBYTE = 3'd5, K_ERROR = 3'd6
    } t_kind;

    localparam logic [63:0] ErrChar   = 64'd0;
    localparam logic [63:0] ErrUnterm = 64'd1;
    localparam logic [63:0] ErrFull   = 64'd2;

    localparam logic [7:0] ChBackslash = 8'd92;
    localparam logic [7:0] ChQuote     = 8'd39;
    localparam logic [7:0] ChNewline   = 8'd10;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [21:0] start;
        logic [22:0] length;
        logic [22:0] line;
    } t_tok;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, c[3:0] - 4'd0};
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            "n":     return 8'd10;
            "t":     return 8'd9;
            "r":     return 8'd13;
            "0":     return 8'd0;
            default: return c;
        endcase
    endfunction

    function automatic logic [3:0] pair_code(input logic [7:0] f, input logic [7:0] c);
        if (c == "=") begin
            if (f == "=") return 4'd1;
            if (f == "!") return 4'd2;
            if (f == "<") return 4'd3;
            if (f == ">") return 4'd4;
        end
        if (f == "&" && c == "&") return 4'd5;
        if (f == "|" && c == "|") return 4'd6;
        if (f == "<" && c == "<") return 4'd7;
        if (f == ">" && c == ">") return 4'd8;
        return 4'd0;
    endfunction

endpackage

[rtl/c_subset_token_lexer_core.sv]
// Output: the tokens of an accepted request are registered in the token queue before they appear.
// Throughput: one request per cycle while the token queue has room; a request can
// give two tokens, which drain one per cycle while i_ready is high through a four-entry queue.
// Reset: synchronous active-low i_rst_n; lexer returns to idle, line one, queue empty.
// ---------------------------------------------------------------------------
// c_subset_token_lexer_core
// Streaming C-subset lexer: byte requests in, tokens out.
// ---------------------------------------------------------------------------
module c_subset_token_lexer_core #(
    parameter int unsigned P_MAX_SOURCE   = cstl_pkg::MaxSource,
    parameter int unsigned P_MAX_STRINGS  = cstl_pkg::MaxStrings,
    parameter int unsigned P_STRING_STORE = cstl_pkg::StringStore
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_src_byte,
    input  logic               i_is_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_tok_kind,
    output logic signed [63:0] o_tok_value,
    output logic [21:0]        o_tok_start,
    output logic [22:0]        o_tok_length,
    output logic [22:0]        o_tok_line,
    output logic               o_tok_last
);
    import cstl_pkg::*;

    logic       w_go, w_space;
    logic [1:0] w_cnt;
    t_tok       w_t0, w_t1, w_out;

    assign o_ready = w_space;
    assign w_go    = i_valid && w_space;

    cstl_lex_step #(
        .P_MAX_SOURCE(P_MAX_SOURCE), .P_MAX_STRINGS(P_MAX_STRINGS),
        .P_STRING_STORE(P_STRING_STORE)
    ) u_step (
        .i_clk, .i_rst_n, .i_go(w_go), .i_byte(i_src_byte), .i_end(i_is_end),
        .o_cnt(w_cnt), .o_tok0(w_t0), .o_tok1(w_t1)
    );

    cstl_out_buf u_buf (
        .i_clk, .i_rst_n, .i_push(w_go), .i_cnt(w_cnt), .i_tok0(w_t0), .i_tok1(w_t1),
        .o_space(w_space), .o_valid, .i_ready, .o_tok(w_out), .o_last(o_tok_last)
    );

    assign o_tok_kind   = w_out.kind;
    assign o_tok_value  = w_out.value;
    assign o_tok_start  = w_out.start;
    assign o_tok_length = w_out.length;
    assign o_tok_line   = w_out.line;
endmodule

[rtl/cstl_out_buf.sv]
// ---------------------------------------------------------------------------
// cstl_out_buf
// Four-entry token queue: takes up to two tokens per request, drains one
// per cycle while i_ready is high.
// ---------------------------------------------------------------------------
module cstl_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [1:0]     i_cnt,
    input  cstl_pkg::t_tok i_tok0,
    input  cstl_pkg::t_tok i_tok1,
    output logic           o_space,
    output logic           o_valid,
    input  logic           i_ready,
    output cstl_pkg::t_tok o_tok,
    output logic           o_last
);
    import cstl_pkg::*;

    t_tok       r_q [4];
    logic [3:0] r_lastq;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       w_pop;
    logic [1:0] w_wr;

    assign o_valid = r_cnt != 3'd0;
    assign o_tok   = r_q[r_rd];
    assign o_last  = r_lastq[r_rd];
    assign w_pop   = o_valid && i_ready;
    assign o_space = r_cnt <= 3'd2;
    assign w_wr    = r_rd + r_cnt[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + (i_push ? {1'b0, i_cnt} : 3'd0) - {2'b0, w_pop};
        end
        if (i_push && i_cnt != 2'd0) begin
            r_q[w_wr]     <= i_tok0;
            r_lastq[w_wr] <= i_cnt == 2'd1;
            if (i_cnt == 2'd2) begin
                r_q[w_wr + 2'd1]     <= i_tok1;
                r_lastq[w_wr + 2'd1] <= 1'b1;
            end
        end
    end

    `include "c_subset_token_lexer_core_assert.svh"
    `CSTL_ASSERT(a_no_overflow, r_cnt <= 3'd4, "token queue overflow")
    `CSTL_ASSERT(a_push_room, i_push |-> r_cnt - {2'b0, w_pop} + {1'b0, i_cnt} <= 3'd4, "push without room")
    `CSTL_ASSERT(a_pop_moves, w_pop |=> r_rd == $past(r_rd) + 2'd1, "read pointer stuck")
endmodule

[rtl/cstl_lex_step.sv]
// ---------------------------------------------------------------------------
// cstl_lex_step
// Lexer state and combinational per-byte update, registered on each accepted request.
// ---------------------------------------------------------------------------
module cstl_lex_step #(
    parameter int unsigned P_MAX_SOURCE   = cstl_pkg::MaxSource,
    parameter int unsigned P_MAX_STRINGS  = cstl_pkg::MaxStrings,
    parameter int unsigned P_STRING_STORE = cstl_pkg::StringStore
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [7:0]     i_byte,
    input  logic           i_end,
    output logic [1:0]     o_cnt,
    output cstl_pkg::t_tok o_tok0,
    output cstl_pkg::t_tok o_tok1
);
    import cstl_pkg::*;

    t_mode       r_mode, n_mode;
    logic [63:0] r_acc, n_acc;
    logic [21:0] r_start, n_start;
    logic [22:0] r_len, n_len;
    logic [24:0] r_pos, n_pos;
    logic [22:0] r_line, n_line;
    logic [16:0] r_scnt, n_scnt;
    logic [24:0] r_sofs, n_sofs;
    logic [7:0]  r_pend, n_pend;

    t_tok        w_t [2];
    logic [1:0]  w_n;
    logic [4:0]  w_hv;
    logic [3:0]  w_pc;
    logic [25:0] w_room;
    logic [7:0]  w_c;
    logic        w_idle;

    assign o_cnt  = w_n;
    assign o_tok0 = w_t[0];
    assign o_tok1 = w_t[1];
    assign w_hv   = hex_val(i_byte);
    assign w_pc   = pair_code(r_pend, i_byte);
    assign w_room = {1'b0, r_sofs} + {3'b0, r_len};

    always_comb begin
        n_mode = r_mode; n_acc = r_acc; n_start = r_start; n_len = r_len;
        n_pos = r_pos; n_line = r_line; n_scnt = r_scnt; n_sofs = r_sofs;
        n_pend = r_pend;
        w_n = 2'd0;
        w_idle = 1'b0;
        w_c = i_byte;
        for (int k = 0; k < 2; k++) begin
            w_t[k] = '{kind: K_EOF, value: '0, start: '0, length: '0, line: r_line};
        end
        if (i_go) begin
            if (i_end || (r_mode != M_DONE && r_mode != M_ERROR &&
                    (i_byte == 8'd0 || r_pos >= 25'(P_MAX_SOURCE)))) begin
                // flush pending token, then eof or error
                n_mode = M_DONE;
                case (r_mode)
                    M_IDENT: begin
                        w_t[0] = '{K_IDENT, 64'd0, r_start, r_len, r_line}; w_n = 2'd1;
                    end
                    M_ZERO, M_DEC, M_HEX: begin
                        w_t[0] = '{K_NUM, r_acc, 22'd0, 23'd0, r_line}; w_n = 2'd1;
                    end
                    M_PEND: begin
                        w_t[0] = '{K_PUNCT, {56'd0, r_pend}, 22'd0, 23'd0, r_line};
                        w_n = 2'd1;
                    end
                    M_SLASH: begin
                        w_t[0] = '{K_PUNCT, 64'd47, 22'd0, 23'd0, r_line}; w_n = 2'd1;
                    end
                    default: ;
                endcase
                if (r_mode inside {M_CHOPEN, M_CHESC, M_CHCLOSE}) begin
                    w_t[0] = '{K_ERROR, ErrChar, 22'd0, 23'd0, r_line}; w_n = 2'd1;
                    n_mode = M_ERROR;
                end else if (r_mode inside {M_STR, M_STRESC}) begin
                    w_t[0] = '{K_ERROR, ErrUnterm, 22'd0, 23'd0, r_line}; w_n = 2'd1;
                    n_mode = M_ERROR;
                end else if (r_mode != M_DONE && r_mode != M_ERROR) begin
                    w_t[w_n[0]] = '{K_EOF, 64'd0, 22'd0, 23'd0, r_line};
                    w_n = w_n + 2'd1;
                end
                if (i_end) begin
                    n_mode = M_IDLE; n_acc = '0; n_start = '0; n_len = '0; n_pos = '0;
                    n_line = 23'd1; n_scnt = '0; n_sofs = '0; n_pend = '0;
                end
            end else if (r_mode != M_DONE && r_mode != M_ERROR) begin
                n_pos = r_pos + 25'd1;
                case (r_mode)
                    M_IDENT: begin
                        if (is_letter(w_c) || is_digit(w_c)) n_len = r_len + 23'd1;
                        else begin
                            w_t[0] = '{K_IDENT, 64'd0, r_start, r_len, r_line};
                            w_n = 2'd1; w_idle = 1'b1;
                        end
                    end
                    M_ZERO: begin
                        if (w_c == "x" || w_c == "X") n_mode = M_HEX;
                        else if (is_digit(w_c)) begin
                            n_mode = M_DEC; n_acc = {60'd0, w_c[3:0]};
                        end else begin
                            w_t[0] = '{K_NUM, 64'd0, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; w_idle = 1'b1;
                        end
                    end
                    M_DEC: begin
                        if (is_digit(w_c))
                            n_acc = {r_acc[60:0], 3'b0} + {r_acc[62:0], 1'b0}
                                + {60'd0, w_c[3:0]};
                        else begin
                            w_t[0] = '{K_NUM, r_acc, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; w_idle = 1'b1;
                        end
                    end
                    M_HEX: begin
                        if (!w_hv[4]) n_acc = {r_acc[59:0], w_hv[3:0]};
                        else begin
                            w_t[0] = '{K_NUM, r_acc, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; w_idle = 1'b1;
                        end
                    end
                    M_PEND: begin
                        if (w_pc != 4'd0) begin
                            w_t[0] = '{K_PUNCT, {60'd0, w_pc}, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; n_mode = M_IDLE;
                        end else begin
                            w_t[0] = '{K_PUNCT, {56'd0, r_pend}, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; w_idle = 1'b1;
                        end
                    end
                    M_SLASH: begin
                        if (w_c == "/") n_mode = M_LINECMT;
                        else if (w_c == "*") n_mode = M_BLOCK;
                        else begin
                            w_t[0] = '{K_PUNCT, 64'd47, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; w_idle = 1'b1;
                        end
                    end
                    M_LINECMT: begin
                        if (w_c == ChNewline) begin
                            n_line = r_line + 23'd1; n_mode = M_IDLE;
                        end
                    end
                    M_BLOCK, M_BSTAR: begin
                        if (r_mode == M_BSTAR && w_c == "/") n_mode = M_IDLE;
                        else begin
                            if (w_c == ChNewline) n_line = r_line + 23'd1;
                            n_mode = (w_c == "*") ? M_BSTAR : M_BLOCK;
                        end
                    end
                    M_CHOPEN: begin
                        if (w_c == ChBackslash) n_mode = M_CHESC;
                        else begin
                            n_acc = {56'd0, w_c}; n_mode = M_CHCLOSE;
                        end
                    end
                    M_CHESC: begin
                        n_acc = {56'd0, unescape(w_c)}; n_mode = M_CHCLOSE;
                    end
                    M_CHCLOSE: begin
                        if (w_c != ChQuote) begin
                            w_t[0] = '{K_ERROR, ErrChar, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; n_mode = M_ERROR;
                        end else begin
                            w_t[0] = '{K_NUM, {{56{r_acc[7]}}, r_acc[7:0]}, 22'd0, 23'd0,
                                r_line};
                            w_n = 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_STR, M_STRESC: begin
                        if (r_mode == M_STR && w_c == "\"") begin
                            if (w_room >= 26'(P_STRING_STORE)) begin
                                w_t[0] = '{K_ERROR, ErrFull, 22'd0, 23'd0, r_line};
                                w_n = 2'd1; n_mode = M_ERROR;
                            end else begin
                                w_t[0] = '{K_STRING, {47'd0, r_scnt}, r_sofs[21:0],
                                    r_len + 23'd1, r_line};
                                w_n = 2'd1;
                                n_sofs = w_room[24:0] + 25'd1;
                                n_scnt = r_scnt + 17'd1;
                                n_mode = M_IDLE;
                            end
                        end else if (r_mode == M_STR && w_c == ChBackslash) begin
                            n_mode = M_STRESC;
                        end else if (w_room >= 26'(P_STRING_STORE)) begin
                            w_t[0] = '{K_ERROR, ErrFull, 22'd0, 23'd0, r_line};
                            w_n = 2'd1; n_mode = M_ERROR;
                        end else begin
                            w_t[0] = '{K_SBYTE,
                                {56'd0, (r_mode == M_STRESC) ? unescape(w_c) : w_c},
                                22'd0, 23'd0, r_line};
                            w_n = 2'd1; n_len = r_len + 23'd1; n_mode = M_STR;
                        end
                    end
                    default: w_idle = 1'b1;
                endcase
                if (w_idle) begin
                    n_mode = M_IDLE;
                    if (w_c == ChNewline) n_line = r_line + 23'd1;
                    else if (w_c <= 8'd32 || w_c >= 8'd128) n_mode = M_IDLE;
                    else if (is_letter(w_c)) begin
                        n_mode = M_IDENT; n_start = r_pos[21:0]; n_len = 23'd1;
                    end else if (w_c == "0") begin
                        n_mode = M_ZERO; n_acc = '0;
                    end else if (is_digit(w_c)) begin
                        n_mode = M_DEC; n_acc = {60'd0, w_c[3:0]};
                    end else if (w_c == ChQuote) n_mode = M_CHOPEN;
                    else if (w_c == "\"") begin
                        if (r_scnt >= 17'(P_MAX_STRINGS)) begin
                            w_t[w_n[0]] = '{K_ERROR, ErrFull, 22'd0, 23'd0, r_line};
                            w_n = w_n + 2'd1; n_mode = M_ERROR;
                        end else begin
                            n_mode = M_STR; n_len = '0;
                        end
                    end else if (w_c == "/") n_mode = M_SLASH;
                    else if (w_c == "=" || w_c == "!" || w_c == "<" || w_c == ">" ||
                            w_c == "&" || w_c == "|") begin
                        n_mode = M_PEND; n_pend = w_c;
                    end else begin
                        w_t[w_n[0]] = '{K_PUNCT, {56'd0, w_c}, 22'd0, 23'd0, r_line};
                        w_n = w_n + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_acc <= '0; r_start <= '0; r_len <= '0; r_pos <= '0;
            r_line <= 23'd1; r_scnt <= '0; r_sofs <= '0; r_pend <= '0;
        end else begin
            r_mode <= n_mode; r_acc <= n_acc; r_start <= n_start; r_len <= n_len;
            r_pos <= n_pos; r_line <= n_line; r_scnt <= n_scnt; r_sofs <= n_sofs;
            r_pend <= n_pend;
        end
    end

    `include "c_subset_token_lexer_core_assert.svh"
    `CSTL_ASSERT(a_idle_no_tok, !i_go |-> w_n == 2'd0, "token without request")
    `CSTL_ASSERT(a_end_restarts, (i_go && i_end) |=> r_mode == M_IDLE && r_pos == 25'd0, "end did not restart")
    `CSTL_ASSERT(a_line_pos, r_line != 23'd0, "line count wrapped to zero")
endmodule

[dv/c_subset_token_lexer_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Token checker for the C-subset lexer core
// Watches the byte and token channels, predicts the tokens each accepted
// request yields and compares them field by field in arrival order.
// ---------------------------------------------------------------------------
module c_subset_token_lexer_checker #(
    parameter int unsigned P_MAX_SOURCE   = cstl_pkg::MaxSource,
    parameter int unsigned P_MAX_STRINGS  = cstl_pkg::MaxStrings,
    parameter int unsigned P_STRING_STORE = cstl_pkg::StringStore
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_src_byte,
    input  logic               i_is_end,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [2:0]         i_tok_kind,
    input  logic signed [63:0] i_tok_value,
    input  logic [21:0]        i_tok_start,
    input  logic [22:0]        i_tok_length,
    input  logic [22:0]        i_tok_line,
    input  logic               i_tok_last,
    output int                 o_fail_count,
    output int                 o_tokens_pending
);
    import cstl_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [63:0] value;
        logic [21:0] start;
        logic [22:0] length;
        logic [22:0] line;
        logic        last;
    } lex_tok_t;

    t_mode       mode;
    logic [63:0] accum;
    logic [21:0] tok_begin;
    logic [22:0] tok_len;
    logic [22:0] src_pos;
    logic [22:0] line_no;
    logic [13:0] str_count;
    logic [20:0] store_ofs;
    logic [7:0]  held_op;

    lex_tok_t step_toks[$];
    lex_tok_t tok_expect_q[$];

    function void clear_lexer();
        mode      = M_IDLE;
        accum     = '0;
        tok_begin = '0;
        tok_len   = '0;
        src_pos   = '0;
        line_no   = 23'd1;
        str_count = '0;
        store_ofs = '0;
        held_op   = '0;
    endfunction

    function void put_tok(t_kind k, logic [63:0] v, logic [21:0] s, logic [22:0] l);
        lex_tok_t t;
        if (step_toks.size() >= 2) return;
        t.kind   = k;
        t.value  = v;
        t.start  = s;
        t.length = l;
        t.line   = line_no;
        t.last   = 1'b0;
        step_toks.push_back(t);
    endfunction

    function void raise_err(logic [63:0] code);
        put_tok(K_ERROR, code, '0, '0);
        mode = M_ERROR;
    endfunction

    function bit letter_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function int hex_nibble(logic [7:0] c);
        if (digit_ch(c)) return int'(c) - 48;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        return -1;
    endfunction

    function logic [7:0] decode_esc(logic [7:0] c);
        case (c)
            "n":     return 8'd10;
            "t":     return 8'd9;
            "r":     return 8'd13;
            "0":     return 8'd0;
            default: return c;
        endcase
    endfunction

    function logic [63:0] op_pair(logic [7:0] f, logic [7:0] c);
        if (c == "=") begin
            if (f == "=") return 64'd1;
            if (f == "!") return 64'd2;
            if (f == "<") return 64'd3;
            if (f == ">") return 64'd4;
        end
        if (f == "&" && c == "&") return 64'd5;
        if (f == "|" && c == "|") return 64'd6;
        if (f == "<" && c == "<") return 64'd7;
        if (f == ">" && c == ">") return 64'd8;
        return 64'd0;
    endfunction

    function bit store_full();
        return int'(store_ofs) + int'(tok_len) >= int'(P_STRING_STORE);
    endfunction

    function void store_str_byte(logic [7:0] d);
        if (store_full()) begin
            raise_err(ErrFull);
            return;
        end
        put_tok(K_SBYTE, 64'(d), '0, '0);
        tok_len = tok_len + 23'd1;
        mode = M_STR;
    endfunction

    function void start_token(logic [7:0] c);
        mode = M_IDLE;
        if (c == ChNewline) begin
            line_no = line_no + 23'd1;
            return;
        end
        if (c <= 8'd32 || c >= 8'd128) return;
        if (letter_ch(c)) begin
            mode = M_IDENT;
            tok_begin = src_pos[21:0];
            tok_len = 23'd1;
        end else if (c == "0") begin
            mode = M_ZERO;
            accum = '0;
        end else if (digit_ch(c)) begin
            mode = M_DEC;
            accum = 64'(c - 8'd48);
        end else if (c == ChQuote) begin
            mode = M_CHOPEN;
        end else if (c == "\"") begin
            if (int'(str_count) >= int'(P_MAX_STRINGS)) begin
                raise_err(ErrFull);
                return;
            end
            mode = M_STR;
            tok_len = '0;
        end else if (c == "/") begin
            mode = M_SLASH;
        end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|") begin
            mode = M_PEND;
            held_op = c;
        end else begin
            put_tok(K_PUNCT, 64'(c), '0, '0);
        end
    endfunction

    function void lex_byte(logic [7:0] c);
        logic [63:0] code;
        int          nib;
        case (mode)
            M_IDENT: begin
                if (letter_ch(c) || digit_ch(c)) begin
                    tok_len = tok_len + 23'd1;
                end else begin
                    put_tok(K_IDENT, '0, tok_begin, tok_len);
                    start_token(c);
                end
            end
            M_ZERO: begin
                if (c == "x" || c == "X") begin
                    mode = M_HEX;
                end else if (digit_ch(c)) begin
                    mode = M_DEC;
                    accum = 64'(c - 8'd48);
                end else begin
                    put_tok(K_NUM, '0, '0, '0);
                    start_token(c);
                end
            end
            M_DEC: begin
                if (digit_ch(c)) begin
                    accum = accum * 64'd10 + 64'(c - 8'd48);
                end else begin
                    put_tok(K_NUM, accum, '0, '0);
                    start_token(c);
                end
            end
            M_HEX: begin
                nib = hex_nibble(c);
                if (nib >= 0) begin
                    accum = accum * 64'd16 + 64'(nib);
                end else begin
                    put_tok(K_NUM, accum, '0, '0);
                    start_token(c);
                end
            end
            M_PEND: begin
                code = op_pair(held_op, c);
                if (code != 0) begin
                    put_tok(K_PUNCT, code, '0, '0);
                    mode = M_IDLE;
                end else begin
                    put_tok(K_PUNCT, 64'(held_op), '0, '0);
                    start_token(c);
                end
            end
            M_SLASH: begin
                if (c == "/") mode = M_LINECMT;
                else if (c == "*") mode = M_BLOCK;
                else begin
                    put_tok(K_PUNCT, 64'("/"), '0, '0);
                    start_token(c);
                end
            end
            M_LINECMT: begin
                if (c == ChNewline) begin
                    line_no = line_no + 23'd1;
                    mode = M_IDLE;
                end
            end
            M_BLOCK, M_BSTAR: begin
                if (mode == M_BSTAR && c == "/") begin
                    mode = M_IDLE;
                end else begin
                    if (c == ChNewline) line_no = line_no + 23'd1;
                    mode = (c == "*") ? M_BSTAR : M_BLOCK;
                end
            end
            M_CHOPEN: begin
                if (c == ChBackslash) begin
                    mode = M_CHESC;
                end else begin
                    accum = 64'(c);
                    mode = M_CHCLOSE;
                end
            end
            M_CHESC: begin
                accum = 64'(decode_esc(c));
                mode = M_CHCLOSE;
            end
            M_CHCLOSE: begin
                if (c != ChQuote) begin
                    raise_err(ErrChar);
                end else begin
                    put_tok(K_NUM, {{56{accum[7]}}, accum[7:0]}, '0, '0);
                    mode = M_IDLE;
                end
            end
            M_STR: begin
                if (c == "\"") begin
                    if (store_full()) begin
                        raise_err(ErrFull);
                    end else begin
                        put_tok(K_STRING, 64'(str_count), 22'(store_ofs), tok_len + 23'd1);
                        store_ofs = store_ofs + 21'(tok_len) + 21'd1;
                        str_count = str_count + 14'd1;
                        mode = M_IDLE;
                    end
                end else if (c == ChBackslash) begin
                    mode = M_STRESC;
                end else begin
                    store_str_byte(c);
                end
            end
            M_STRESC: store_str_byte(decode_esc(c));
            M_DONE, M_ERROR: ;
            default: start_token(c);
        endcase
    endfunction

    function void finish_source();
        case (mode)
            M_IDENT: put_tok(K_IDENT, '0, tok_begin, tok_len);
            M_ZERO, M_DEC, M_HEX: put_tok(K_NUM, accum, '0, '0);
            M_PEND: put_tok(K_PUNCT, 64'(held_op), '0, '0);
            M_SLASH: put_tok(K_PUNCT, 64'("/"), '0, '0);
            M_CHOPEN, M_CHESC, M_CHCLOSE: begin
                raise_err(ErrChar);
                return;
            end
            M_STR, M_STRESC: begin
                raise_err(ErrUnterm);
                return;
            end
            M_DONE, M_ERROR: return;
            default: ;
        endcase
        put_tok(K_EOF, '0, '0, '0);
        mode = M_DONE;
    endfunction

    function void predict_request(logic [7:0] c, logic is_end);
        step_toks.delete();
        if (is_end) begin
            finish_source();
            clear_lexer();
        end else if (mode != M_DONE && mode != M_ERROR) begin
            if (c == 8'd0 || int'(src_pos) >= int'(P_MAX_SOURCE)) begin
                finish_source();
            end else begin
                lex_byte(c);
                src_pos = src_pos + 23'd1;
            end
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) tok_expect_q.push_back(step_toks[i]);
    endfunction

    initial begin
        o_fail_count = 0;
        o_tokens_pending = 0;
        clear_lexer();
    end

    always @(posedge i_clk) begin
        lex_tok_t want;
        if (!i_rst_n) begin
            clear_lexer();
            tok_expect_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_request(i_src_byte, i_is_end);
            if (i_out_valid && i_out_ready) begin
                if (tok_expect_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected token kind=%0d value=%0h", $time,
                                 i_tok_kind, i_tok_value);
                end else begin
                    want = tok_expect_q.pop_front();
                    if (i_tok_kind !== want.kind || i_tok_value !== want.value ||
                        i_tok_start !== want.start || i_tok_length !== want.length ||
                        i_tok_line !== want.line || i_tok_last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: token mismatch exp kind=%0d val=%0h st=%0d ",
                                      "len=%0d line=%0d last=%0b got kind=%0d val=%0h ",
                                      "st=%0d len=%0d line=%0d last=%0b"}, $time,
                                     want.kind, want.value, want.start, want.length,
                                     want.line, want.last, i_tok_kind, i_tok_value,
                                     i_tok_start, i_tok_length, i_tok_line, i_tok_last);
                    end
                end
            end
        end
        o_tokens_pending = tok_expect_q.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the C-subset lexer core
// Feeds directed and random C-like sources with stalls on both channels;
// a separate checker predicts and compares every token.
// ---------------------------------------------------------------------------
module tb;
    import cstl_pkg::*;

    localparam int RandReqs = 1380;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_src_byte;
    logic               i_is_end;
    logic               o_valid;
    logic               i_ready;
    logic [2:0]         o_tok_kind;
    logic signed [63:0] o_tok_value;
    logic [21:0]        o_tok_start;
    logic [22:0]        o_tok_length;
    logic [22:0]        o_tok_line;
    logic               o_tok_last;
    int                 fail_count;
    int                 tokens_pending;

    bit idle_on;
    bit long_hold;
    int req_count;

    c_subset_token_lexer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_src_byte(i_src_byte), .i_is_end(i_is_end), .o_valid(o_valid),
        .i_ready(i_ready), .o_tok_kind(o_tok_kind), .o_tok_value(o_tok_value),
        .o_tok_start(o_tok_start), .o_tok_length(o_tok_length),
        .o_tok_line(o_tok_line), .o_tok_last(o_tok_last)
    );

    c_subset_token_lexer_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_src_byte(i_src_byte), .i_is_end(i_is_end), .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_tok_kind(o_tok_kind), .i_tok_value(o_tok_value),
        .i_tok_start(o_tok_start), .i_tok_length(o_tok_length),
        .i_tok_line(o_tok_line), .i_tok_last(o_tok_last),
        .o_fail_count(fail_count), .o_tokens_pending(tokens_pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // token sink with random backpressure bursts and one long hold
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (120) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_req(input logic [7:0] b, input logic e);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_src_byte <= b;
        i_is_end   <= e;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        req_count++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_req(s[i], 1'b0);
    endtask

    task automatic end_source();
        send_req(8'($urandom), 1'b1);
    endtask

    task automatic drain_pause();
        i_valid <= 1'b0;
        wait (tokens_pending == 0);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic send_fragment();
        int n;
        string ops;
        ops = "==!=<=>=&&||<<>>";
        case ($urandom_range(0, 11))
            0: begin
                send_req(pick("abcxyzABCXYZ_"), 1'b0);
                repeat ($urandom_range(0, 6)) send_req(pick("az09_QZk7"), 1'b0);
            end
            1: repeat ($urandom_range(1, 22)) send_req(pick("0123456789"), 1'b0);
            2: begin
                send_req("0", 1'b0);
                send_req(pick("xX"), 1'b0);
                repeat ($urandom_range(0, 18)) send_req(pick("0123456789abcdefABCDEF"), 1'b0);
            end
            3: begin
                send_req(ChQuote, 1'b0);
                if ($urandom_range(0, 2) == 0) begin
                    send_req(ChBackslash, 1'b0);
                    send_req(pick("ntr0\\'ax"), 1'b0);
                end else begin
                    send_req(8'($urandom_range(1, 255)), 1'b0);
                end
                if ($urandom_range(0, 9) != 0) send_req(ChQuote, 1'b0);
                else send_req(pick("ab'"), 1'b0);
            end
            4, 5: begin
                send_req("\"", 1'b0);
                repeat ($urandom_range(0, 8)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_req(ChBackslash, 1'b0);
                        send_req(pick("ntr0\\\"q"), 1'b0);
                    end else begin
                        send_req(pick("hello world\t~"), 1'b0);
                    end
                end
                send_req("\"", 1'b0);
            end
            6: begin
                n = 2 * $urandom_range(0, 7);
                if ($urandom_range(0, 1) == 0) begin
                    send_req(ops[n], 1'b0);
                    send_req(ops[n + 1], 1'b0);
                end else begin
                    send_req(pick("=!<>&|+-*;(){}[],.~^%?:/#"), 1'b0);
                end
            end
            7: begin
                send_text("// ");
                repeat ($urandom_range(0, 4)) send_req(pick("ab */\""), 1'b0);
                send_req(ChNewline, 1'b0);
            end
            8: begin
                send_text("/*");
                repeat ($urandom_range(0, 6)) send_req(pick("a*\n/ "), 1'b0);
                send_text("*/");
            end
            9: repeat ($urandom_range(1, 3))
                send_req($urandom_range(0, 1) ? pick(" \t\n\r") : 8'($urandom_range(128, 255)),
                         1'b0);
            default: send_req(8'($urandom_range(1, 255)), 1'b0);
        endcase
    endtask

    task automatic send_source();
        repeat ($urandom_range(1, 30)) begin
            send_fragment();
            if ($urandom_range(0, 2) != 0) send_req(pick(" \n\t"), 1'b0);
        end
        if ($urandom_range(0, 4) == 0) begin
            send_req(8'd0, 1'b0);
            repeat ($urandom_range(0, 3)) send_req(8'($urandom), 1'b0);
        end
        end_source();
    endtask

    initial begin
        int stop_at;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_src_byte = '0;
        i_is_end   = 1'b0;
        idle_on    = 1'b1;
        long_hold  = 1'b0;
        req_count  = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        end_source();
        send_text("ab_9 0 0 07 0x1F 0XaB 18446744073709551617 'a' '\\n' '\\'' ");
        send_req(ChQuote, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(ChQuote, 1'b0);
        send_text(" \"h\\t\\\"\\0\" == != <= >= && || << >> < = ! > & | / + // c\n");
        send_text("/* * \n */ x");
        send_req(8'd0, 1'b0);
        send_text("zz");
        end_source();
        send_text("'ab");
        end_source();
        send_text("\"abc");
        end_source();
        send_req(ChQuote, 1'b0);
        end_source();
        send_text("\"x\\");
        end_source();
        send_text("a /");
        end_source();

        drain_pause();
        send_text("\"\" \"q\" ");
        end_source();

        long_hold = 1'b1;
        stop_at = req_count + RandReqs;
        while (req_count < stop_at) begin
            if (req_count > stop_at - 200) idle_on = 1'b0;
            if ($urandom_range(0, 40) == 0) drain_pause();
            send_source();
        end
        i_valid <= 1'b0;
        wait (tokens_pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
